[rtl/core/sha256_message_hasher_macros.svh]
// assertion helpers for the sha-256 message hasher
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define SMH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define SMH_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define SMH_ASSERT(name, prop, msg)
`define SMH_ASSERT_NR(name, prop, msg)

`endif

`endif

[rtl/core/sha256mh_pkg.sv]
package sha256mh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  // input request
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       message_end;
  } in_req_t;

  // output request
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_done;
  } out_req_t;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic load;  // copy chaining value into the working variables
    logic step;  // run one compression round
    logic rot;   // rotate working variables by one word
  } rnd_ctrl_t;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;

  // initial hash, element 7 first
  localparam hash_t InitHash = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[rtl/core/sha256mh_round.sv]
module sha256mh_round (
  input  logic                    clk_i,
  input  sha256mh_pkg::rnd_ctrl_t ctrl_i,
  input  sha256mh_pkg::hash_t     hash_i,
  input  sha256mh_pkg::word_t     w_i,
  input  sha256mh_pkg::word_t     k_i,
  output sha256mh_pkg::word_t     work0_o
);
  import sha256mh_pkg::*;

  hash_t work_q;
  hash_t work_d;
  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1  = work_q[7] + big_sigma1(work_q[4]) + ch + k_i + w_i;
  assign t2  = big_sigma0(work_q[0]) + maj;

  always_comb begin
    work_d = work_q;
    if (ctrl_i.load) begin
      work_d = hash_i;
    end else if (ctrl_i.step) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end else if (ctrl_i.rot) begin
      // feed words out one by one for the chaining update
      for (int i = 0; i < 7; i++) begin
        work_d[i] = work_q[i+1];
      end
      work_d[7] = work_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign work0_o = work_q[0];

endmodule

[rtl/core/sha256_message_hasher.sv]
// sha-256 over a byte stream: message bytes are taken only while the sequencer is idle
// a full block runs 64 rounds on the shared round unit, then 8 chaining-update steps
// end of message: padding bytes shift in, then one block (two if length spills) is hashed
// the digest then leaves as 8 words, one per accepted output cycle
// async active-low reset: chaining value to the initial hash, byte count to zero, idle
module sha256_message_hasher (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sha256mh_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sha256mh_pkg::out_req_t out_req_o
);
  import sha256mh_pkg::*;

  `include "sha256_message_hasher_macros.svh"

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,  // waiting for message bytes
    ST_PAD  = 5'b00010,  // shifting in padding and length bytes
    ST_COMP = 5'b00100,  // 64 compression rounds
    ST_FOLD = 5'b01000,  // adding working variables into the chaining value
    ST_OUT  = 5'b10000   // sending digest words
  } state_e;

  state_e        state_q, state_d;
  logic [5:0]    round_q, round_d;   // round index, also fold and word counter
  logic [5:0]    pos_q, pos_d;       // byte position within the current block
  logic [60:0]   count_q, count_d;   // message length in bytes, wraps
  logic          end_q, end_d;       // message has ended, padding outstanding
  logic          first_q, first_d;   // next padding byte is the 0x80 marker
  logic          extra_q, extra_d;   // length goes into a further block
  logic          last_q, last_d;     // current block is the final one
  logic [511:0]  blk_q;              // block buffer, doubles as schedule window
  hash_t         hash_q;             // chaining value

  rnd_ctrl_t     ctrl;
  logic          in_acc;
  logic          out_acc;
  logic          extra_now;
  logic [63:0]   len_bits;
  logic [2:0]    len_idx;
  logic [7:0]    pad_byte;
  word_t         w0, w1, w9, w14;
  word_t         w_new;
  word_t         work0;
  logic          round_run;          // a round other than the last is running
  logic [5:0]    round_nxt;
  logic          out_last;           // final digest word accepted

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // schedule window taps, word 0 is the oldest
  assign w0    = blk_q[511:480];
  assign w1    = blk_q[479:448];
  assign w9    = blk_q[223:192];
  assign w14   = blk_q[63:32];
  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  // padding byte: marker, zeros, then the big-endian bit length
  assign len_bits  = {count_q, 3'b000};
  assign len_idx   = 3'd7 - pos_q[2:0];
  assign extra_now = first_q ? (pos_q >= LenPos) : extra_q;
  always_comb begin
    if (first_q) begin
      pad_byte = PadMark;
    end else if ((pos_q >= LenPos) && !extra_q) begin
      pad_byte = len_bits[{len_idx, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    round_d = round_q;
    pos_d   = pos_q;
    count_d = count_q;
    end_d   = end_q;
    first_d = first_q;
    extra_d = extra_q;
    last_d  = last_q;
    ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.byte_present) begin
            pos_d   = pos_q + 6'd1;
            count_d = count_q + 61'd1;
          end
          if (in_req_i.message_end) begin
            end_d   = 1'b1;
            first_d = 1'b1;
          end
          if (in_req_i.byte_present && (pos_q == LastPos)) begin
            state_d   = ST_COMP;
            ctrl.load = 1'b1;
            round_d   = '0;
          end else if (in_req_i.message_end) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        pos_d   = pos_q + 6'd1;
        first_d = 1'b0;
        extra_d = extra_now;
        if (pos_q == LastPos) begin
          state_d   = ST_COMP;
          ctrl.load = 1'b1;
          round_d   = '0;
          if (extra_now) begin
            extra_d = 1'b0;
          end else begin
            last_d = 1'b1;
          end
        end
      end
      ST_COMP: begin
        ctrl.step = 1'b1;
        round_d   = round_q + 6'd1;
        if (round_q == LastPos) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctrl.rot = 1'b1;
        round_d  = round_q + 6'd1;
        if (round_q[2:0] == 3'd7) begin
          round_d = '0;
          if (last_q) begin
            state_d = ST_OUT;
          end else if (end_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          round_d = round_q + 6'd1;
          if (round_q[2:0] == 3'd7) begin
            round_d = '0;
            state_d = ST_IDLE;
            end_d   = 1'b0;
            last_d  = 1'b0;
            count_d = '0;
            pos_d   = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      pos_q   <= '0;
      count_q <= '0;
      end_q   <= 1'b0;
      first_q <= 1'b0;
      extra_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      end_q   <= end_d;
      first_q <= first_d;
      extra_q <= extra_d;
      last_q  <= last_d;
    end
  end

  // block buffer: bytes shift in at the bottom, schedule words shift out at the top
  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.byte_present) begin
      blk_q <= {blk_q[503:0], in_req_i.message_byte};
    end else if (state_q == ST_PAD) begin
      blk_q <= {blk_q[503:0], pad_byte};
    end else if (state_q == ST_COMP) begin
      blk_q <= {blk_q[479:0], w_new};
    end
  end

  // chaining value: adder rotation while folding, plain rotation while sending words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= InitHash;
    end else if (state_q == ST_FOLD) begin
      hash_q <= {hash_q[0] + work0, hash_q[7:1]};
    end else if (out_acc) begin
      if (round_q[2:0] == 3'd7) begin
        hash_q <= InitHash;
      end else begin
        hash_q <= {hash_q[0], hash_q[7:1]};
      end
    end
  end

  sha256mh_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .hash_i  (hash_q),
    .w_i     (w0),
    .k_i     (RoundK[round_q]),
    .work0_o (work0)
  );

  assign out_req_o.digest_word = hash_q[0];
  assign out_req_o.word_number = round_q[2:0];
  assign out_req_o.digest_done = (round_q[2:0] == 3'd7);

  assign round_run = (state_q == ST_COMP) && (round_q != LastPos);
  assign round_nxt = round_q + 6'd1;
  assign out_last  = out_acc && out_req_o.digest_done;

  // input and output sides are never open together
  `SMH_ASSERT(a_side_excl, !(in_ready_o && out_valid_o), "input and output open together")
  // rounds advance one per cycle without a gap
  `SMH_ASSERT(a_round_step, round_run |=> (round_q == $past(round_nxt)), "round counter slipped")
  // a digest always starts with word zero
  `SMH_ASSERT(a_out_first, $rose(out_valid_o) |-> (out_req_o.word_number == 3'd0), "bad first word")
  // block position tracks the byte count while idle
  `SMH_ASSERT(a_pos_track, (state_q == ST_IDLE) |-> (pos_q == count_q[5:0]), "position off count")
  // after the final word the next message starts from scratch
  `SMH_ASSERT(a_clear_after, out_last |=> in_ready_o && (count_q == 61'd0), "state not cleared")

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  import sha256mh_pkg::*;

  // no-progress limit: a long receiver hold-off plus a two-block padding pass fit well inside
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned ReportLimit   = 10;

  // sha-256 initial hash, word 0 first
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_req_t out_req_o;

  sha256_message_hasher uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  always #10 clk_i = ~clk_i;

  // requests waiting to be offered, and digest words still owed by the block
  in_req_t  pending_reqs [$];
  out_req_t digest_q [$];

  // predicted hash state
  logic [31:0] chain_h [8];
  logic [7:0]  blk_bytes [64];
  logic [60:0] msg_len;

  // idle rates per phase, in percent
  int unsigned src_idle_pct = 16;
  int unsigned sink_idle_pct = 53;

  int unsigned err_cnt = 0;
  int unsigned gen_items = 0;
  int unsigned bytes_taken = 0;
  int unsigned ignored_taken = 0;
  int unsigned words_checked = 0;
  int unsigned msgs_hashed = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_used = 1'b0;
  logic        in_taken = 1'b0;
  out_req_t    want_w;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of the buffered block into the chaining value
  task automatic absorb_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  // advance the predicted state by one accepted request, queue the digest on message end
  task automatic hash_request(input in_req_t rq);
    logic [63:0] bit_len;
    int unsigned pos;
    out_req_t    wd;
    if (rq.byte_present) begin
      pos = {26'd0, msg_len[5:0]};
      blk_bytes[pos] = rq.message_byte;
      msg_len = msg_len + 61'd1;
      if (pos == 63) absorb_block();
    end
    if (rq.message_end) begin
      pos = {26'd0, msg_len[5:0]};
      blk_bytes[pos] = 8'h80;
      pos++;
      // no room for the length: finish this block and pad a fresh one
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) blk_bytes[i] = 8'h00;
        absorb_block();
        pos = 0;
      end
      for (int i = pos; i < 56; i++) blk_bytes[i] = 8'h00;
      bit_len = {msg_len, 3'b000};
      for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[63-8*i -: 8];
      absorb_block();
      for (int i = 0; i < 8; i++) begin
        wd.digest_word = chain_h[i];
        wd.word_number = 3'(i);
        wd.digest_done = (i == 7);
        digest_q = {digest_q, wd};
      end
      chain_h = IV_TAB;
      msg_len = '0;
    end
  endtask

  initial begin
    chain_h = IV_TAB;
    msg_len = '0;
  end

  task automatic push_req(input logic [7:0] b, input logic present, input logic last);
    in_req_t rq;
    rq.message_byte = b;
    rq.byte_present = present;
    rq.message_end  = last;
    pending_reqs = {pending_reqs, rq};
    gen_items++;
  endtask

  // a message of random bytes, optionally ended by a bare end request, with some noise
  task automatic queue_message(input int unsigned len, input logic bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) push_req(8'($urandom), 1'b0, 1'b0);
      push_req(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) push_req(8'($urandom), 1'b0, 1'b1);
  endtask

  // one padding-boundary message, then mostly short messages up to the quota
  task automatic queue_random_part(input int unsigned edge_len, input int unsigned quota);
    int unsigned start;
    start = gen_items;
    queue_message(edge_len, 1'($urandom_range(1)));
    while (gen_items - start < quota) begin
      if ($urandom_range(9) == 0) queue_message($urandom_range(50, 70), 1'($urandom_range(1)));
      else queue_message($urandom_range(0, 20), $urandom_range(3) == 0);
    end
  endtask

  // sender pause: nothing offered until every owed digest word is back
  task automatic drain();
    @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || digest_q.size() != 0) @(posedge clk_i);
  endtask

  // input driver: new request only once the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_req_i   <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready, blocked during the long hold-off
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && hold_left == 0 && $urandom_range(99) >= sink_idle_pct;
  end

  // one long receiver hold-off at the first digest, so the block backs up into its input
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && rst_ni && out_valid_o) begin
      hold_left <= HoldOffCycles;
      hold_used <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check each accepted digest word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      hash_request(in_req_i);
      if (in_req_i.byte_present) bytes_taken++;
      else if (!in_req_i.message_end) ignored_taken++;
      if (in_req_i.message_end) msgs_hashed++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ReportLimit)
          $display("unexpected digest word %h number %0d done %b", out_req_o.digest_word,
                   out_req_o.word_number, out_req_o.digest_done);
      end else begin
        want_w = digest_q.pop_front();
        words_checked++;
        if (out_req_o.digest_word !== want_w.digest_word ||
            out_req_o.word_number !== want_w.word_number ||
            out_req_o.digest_done !== want_w.digest_done) begin
          err_cnt++;
          if (err_cnt <= ReportLimit)
            $display("digest mismatch: want %h/%0d/%b got %h/%0d/%b", want_w.digest_word,
                     want_w.word_number, want_w.digest_done, out_req_o.digest_word,
                     out_req_o.word_number, out_req_o.digest_done);
        end
      end
    end
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout after %0d cycles without a handshake", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty message right after reset
    push_req(8'h3c, 1'b0, 1'b1);
    // one byte, end on the byte, top value
    push_req(8'hff, 1'b1, 1'b1);
    // one zero byte, then an end request without a byte
    push_req(8'h00, 1'b1, 1'b0);
    push_req(8'h5a, 1'b0, 1'b1);
    // noise only, then empty message: noise must not disturb the state
    push_req(8'hff, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b0);
    push_req(8'ha5, 1'b0, 1'b1);
    // classic three-byte message
    push_req(8'h61, 1'b1, 1'b0);
    push_req(8'h62, 1'b1, 1'b0);
    push_req(8'h63, 1'b1, 1'b1);
    // bytes with noise between them and a bare end
    push_req(8'h80, 1'b1, 1'b0);
    push_req(8'h7f, 1'b0, 1'b0);
    push_req(8'h7f, 1'b1, 1'b0);
    push_req(8'h01, 1'b0, 1'b1);
    drain();

    // length fills the first block exactly up to the length field
    queue_random_part(55, 60);
    drain();

    // length field spills into a second block
    src_idle_pct  = 53;
    sink_idle_pct = 16;
    queue_random_part(56, 60);
    drain();

    // one full block, then a padding-only block
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    queue_random_part(64, 60);
    drain();

    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d messages: %0d bytes, %0d ignored requests, %0d digest words checked",
             msgs_hashed, bytes_taken, ignored_taken, words_checked);
    $display("lengths included empty, bare end, 55/56/64-byte padding edges, three idle mixes");
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
